FILE: rtl/amrcs_pkg.sv
// Shared types, constants and helper functions of the AM radio channel simulator.
// Used by the top level and the divider; depends on nothing.
package amrcs_pkg;

    localparam int ECHO_DELAY_DEF      = 1000;
    localparam int SINE_TABLE_BITS_DEF = 10;

    localparam int NUM_PHASES  = 17;
    localparam int PHASE_IDX_W = 5;
    localparam logic [PHASE_IDX_W-1:0] TONE_INDEX = 5'd12;
    localparam logic [PHASE_IDX_W-1:0] PHASE_LAST = 5'd16;

    localparam int DIV_NW = 51;
    localparam int DIV_DW = 35;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL = 2'd1;
    localparam logic [9:0] LEVEL_RESET = 10'd10;

    localparam logic [2:0] SUM_TERMS = 3'd5;
    localparam logic [12:0] NOISE_WEIGHT = 13'd6554;
    localparam logic [22:0] TONE_BIAS = 23'd3276800;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT_DRAW,
        S_INIT_MOD,
        S_INIT_STEP,
        S_ITEM,
        S_ECHO,
        S_SN_X,
        S_SN_X2,
        S_SN_R1,
        S_SN_R2,
        S_SN_R,
        S_SN_ACC,
        S_FAC,
        S_WGT,
        S_SUM,
        S_DIV,
        S_DIVW,
        S_OUT,
        S_ADV
    } t_state;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    function automatic logic [31:0] xorshift(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x << 13);
        y = y ^ (y >> 17);
        y = y ^ (y << 5);
        return y;
    endfunction

    function automatic logic [17:0] draw_mod(input logic [PHASE_IDX_W-1:0] k);
        case (k)
            5'd0, 5'd12:          return 18'd1000;
            5'd1:                 return 18'd15000;
            5'd2:                 return 18'd40000;
            5'd4, 5'd8, 5'd13:    return 18'd2000;
            5'd5, 5'd9, 5'd14:    return 18'd7000;
            5'd6, 5'd10, 5'd15:   return 18'd50000;
            default:              return 18'd200000;
        endcase
    endfunction

    function automatic logic [17:0] draw_off(input logic [PHASE_IDX_W-1:0] k);
        case (k)
            5'd0:                 return 18'd300;
            5'd1:                 return 18'd17500;
            5'd2:                 return 18'd60000;
            5'd4, 5'd8, 5'd13:    return 18'd1500;
            5'd5, 5'd9, 5'd14:    return 18'd4000;
            5'd6, 5'd10, 5'd15:   return 18'd25000;
            5'd12:                return 18'd0;
            default:              return 18'd150000;
        endcase
    endfunction

    // Fast, medium, long and extra long fading weights; the tone phase scales by 100.
    function automatic logic [14:0] sine_coef(input logic [PHASE_IDX_W-1:0] k);
        case (k)
            5'd0, 5'd4, 5'd8, 5'd13:  return 15'd6554;
            5'd1, 5'd5, 5'd9, 5'd14:  return 15'd13107;
            5'd2, 5'd6, 5'd10, 5'd15: return 15'd19661;
            5'd12:                    return 15'd100;
            default:                  return 15'd26214;
        endcase
    endfunction

    function automatic logic group_end(input logic [PHASE_IDX_W-1:0] k);
        return (k == 5'd3) || (k == 5'd7) || (k == 5'd11) || (k == 5'd16);
    endfunction

    function automatic logic [1:0] group_of(input logic [PHASE_IDX_W-1:0] k);
        case (k)
            5'd3:    return 2'd0;
            5'd7:    return 2'd1;
            5'd11:   return 2'd2;
            default: return 2'd3;
        endcase
    endfunction

    function automatic logic [14:0] group_base(input logic [1:0] g);
        case (g)
            2'd1:    return 15'd19661;
            2'd2:    return 15'd13107;
            default: return 15'd1311;
        endcase
    endfunction

endpackage

FILE: rtl/am_radio_channel_simulator.sv
// Top level of the AM radio channel simulator: sequencer and datapath.
// Depends on amrcs_pkg, amrcs_mul, amrcs_div and amrcs_ram.

// Each accepted beat of payload and background samples yields one output beat, and the next
// beat is accepted only once the sequencer is back in idle. The work goes to seventeen sine
// evaluations through the shared multiplier, the four fade weights, the five mix products, a
// division through the shared divider and, after the output beat, the phase update. While an
// earlier output beat is still stalled, the sequencer waits before it loads the next one,
// which delays both the output beat and the next accepted beat. The first beat after reset
// also draws the seventeen phase steps, each needing two divisions. After reset the echo
// memory is cleared, during which no beat is accepted; configuration writes are always
// accepted.
module am_radio_channel_simulator #(
    parameter int ECHO_DELAY      = amrcs_pkg::ECHO_DELAY_DEF,
    parameter int SINE_TABLE_BITS = amrcs_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_payload_sample,
    input  logic [7:0]                    i_background_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [7:0]                    o_radio_sample,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [amrcs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);

    localparam int ECHO_AW = (ECHO_DELAY > 1) ? $clog2(ECHO_DELAY) : 1;
    localparam int NP      = amrcs_pkg::NUM_PHASES;
    localparam int KW      = amrcs_pkg::PHASE_IDX_W;
    localparam int SB      = SINE_TABLE_BITS;

    amrcs_pkg::t_state r_state, n_state;

    logic [KW-1:0]      r_k;
    logic [2:0]         r_cnt;
    logic [ECHO_AW-1:0] r_clr;
    logic [ECHO_AW-1:0] r_pos;
    logic               r_started;
    logic [31:0]        r_seed;
    logic [9:0]         r_level;
    logic [31:0]        r_rand;
    logic [31:0]        r_step  [NP];
    logic [31:0]        r_phase [NP];
    logic [7:0]         r_noise;
    logic [7:0]         r_payload;
    logic [7:0]         r_bg;
    logic [7:0]         r_echo;
    logic [15:0]        r_prev;
    logic [15:0]        r_mix;
    logic [16:0]        r_x;
    logic [16:0]        r_x2;
    logic               r_neg;
    logic signed [32:0] r_acc;
    logic [22:0]        r_tone;
    logic [26:0]        r_w [4];
    logic [50:0]        r_num;
    logic               r_out_valid;
    logic [7:0]         r_out_sample;

    logic [31:0]        mul_a, mul_b;
    logic [63:0]        p;
    amrcs_pkg::t_div_req div_req;
    logic               div_done;
    logic [amrcs_pkg::DIV_NW-1:0] div_q;
    logic [amrcs_pkg::DIV_DW-1:0] div_r;
    logic               ram_we;
    logic [ECHO_AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]         ram_wdata, ram_rdata;
    logic               out_load;

    logic [31:0]        ph;
    logic [SB-1:0]      sidx;
    logic [1:0]         quad;
    logic [16:0]        x_raw, x_fold;
    logic [15:0]        r1;
    logic [16:0]        r2;
    logic [15:0]        rr;
    logic [14:0]        smag;
    logic signed [32:0] sprod;
    logic [31:0]        fsum;
    logic [1:0]         grp;
    logic [31:0]        base;
    logic [26:0]        w_new;
    logic [27:0]        total;
    logic [50:0]        sum_add;
    logic [15:0]        mix_clip;
    logic [16:0]        res_sum;
    logic [31:0]        d_next;
    logic [9:0]         mod_v;
    logic [11:0]        dtone;
    logic [18:0]        pnorm;
    logic [39:0]        num_tone;
    logic [29:0]        num_p;
    logic [ECHO_AW-1:0] pos_next;

    amrcs_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (p)
    );

    amrcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_q),
        .o_rem   (div_r)
    );

    amrcs_ram #(
        .WIDTH (8),
        .DEPTH (ECHO_DELAY)
    ) u_echo (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ph     = r_phase[r_k];
    assign sidx   = ph[31 -: SB];
    assign quad   = sidx[SB-1 -: 2];
    assign x_raw  = 17'(sidx[SB-3:0]) << (18 - SB);
    assign x_fold = quad[0] ? (17'h10000 - x_raw) : x_raw;
    assign r1     = 16'd42048 - 16'(p[28:16]);
    assign r2     = 17'd102944 - 17'(p[31:16]);
    assign rr     = p[32:17];
    assign smag   = (rr > 16'd32767) ? 15'h7fff : rr[14:0];
    assign sprod  = $signed({3'b000, p[29:0]});
    assign fsum   = r_acc[31:0] + 32'h8000_0000;
    assign grp    = amrcs_pkg::group_of(r_k);
    assign base   = (grp == 2'd0) ? 32'(r_level) : 32'(amrcs_pkg::group_base(grp));
    assign w_new  = (grp == 2'd0) ? p[26:0] : p[42:16];
    assign total  = 28'(r_w[0]) + 28'(r_w[1]) + 28'(r_w[2]) + 28'(r_w[3])
                  + 28'(amrcs_pkg::NOISE_WEIGHT);
    assign sum_add = (r_cnt == amrcs_pkg::SUM_TERMS) ? 51'(p[34:0]) : {1'b0, p[34:0], 15'b0};
    assign mix_clip = (|div_q[50:16]) ? 16'hffff : div_q[15:0];
    assign res_sum  = 17'(r_mix) + 17'(r_prev);
    assign d_next   = amrcs_pkg::xorshift(r_rand);
    assign mod_v    = div_r[9:0];
    assign dtone    = 12'd1000 + 12'({mod_v, 1'b0}) + 12'(mod_v);
    assign pnorm    = 19'(div_r[17:0]) + 19'(amrcs_pkg::draw_off(r_k));
    assign num_tone = 40'd683565276000 + 40'(dtone >> 1);
    assign num_p    = 30'd683565276 + 30'(pnorm >> 1);
    assign pos_next = (r_pos == ECHO_AW'(ECHO_DELAY - 1)) ? '0 : r_pos + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= amrcs_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        mul_a     = '0;
        mul_b     = '0;
        div_req   = '0;
        ram_we    = 1'b0;
        ram_waddr = r_pos;
        ram_wdata = r_payload;
        ram_raddr = r_pos;
        out_load  = 1'b0;
        case (r_state)
            amrcs_pkg::S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                if (r_clr == ECHO_AW'(ECHO_DELAY - 1)) begin
                    n_state = amrcs_pkg::S_IDLE;
                end
            end
            amrcs_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = r_started ? amrcs_pkg::S_ITEM : amrcs_pkg::S_INIT_DRAW;
                end
            end
            amrcs_pkg::S_INIT_DRAW: begin
                div_req.start = 1'b1;
                div_req.num   = 51'(d_next);
                div_req.den   = 35'(amrcs_pkg::draw_mod(r_k));
                n_state       = amrcs_pkg::S_INIT_MOD;
            end
            amrcs_pkg::S_INIT_MOD: begin
                if (div_done) begin
                    div_req.start = 1'b1;
                    if (r_k == amrcs_pkg::TONE_INDEX) begin
                        div_req.num = 51'(num_tone);
                        div_req.den = 35'(dtone);
                    end else begin
                        div_req.num = 51'(num_p);
                        div_req.den = 35'(pnorm);
                    end
                    n_state = amrcs_pkg::S_INIT_STEP;
                end
            end
            amrcs_pkg::S_INIT_STEP: begin
                if (div_done) begin
                    n_state = (r_k == amrcs_pkg::PHASE_LAST) ? amrcs_pkg::S_ITEM
                                                             : amrcs_pkg::S_INIT_DRAW;
                end
            end
            amrcs_pkg::S_ITEM: begin
                n_state = amrcs_pkg::S_ECHO;
            end
            amrcs_pkg::S_ECHO: begin
                n_state = amrcs_pkg::S_SN_X;
            end
            amrcs_pkg::S_SN_X: begin
                mul_a   = 32'(x_fold);
                mul_b   = 32'(x_fold);
                n_state = amrcs_pkg::S_SN_X2;
            end
            amrcs_pkg::S_SN_X2: begin
                mul_a   = 32'(p[32:16]);
                mul_b   = 32'd4640;
                n_state = amrcs_pkg::S_SN_R1;
            end
            amrcs_pkg::S_SN_R1: begin
                mul_a   = 32'(r_x2);
                mul_b   = 32'(r1);
                n_state = amrcs_pkg::S_SN_R2;
            end
            amrcs_pkg::S_SN_R2: begin
                mul_a   = 32'(r_x);
                mul_b   = 32'(r2);
                n_state = amrcs_pkg::S_SN_R;
            end
            amrcs_pkg::S_SN_R: begin
                mul_a   = 32'(smag);
                mul_b   = 32'(amrcs_pkg::sine_coef(r_k));
                n_state = amrcs_pkg::S_SN_ACC;
            end
            amrcs_pkg::S_SN_ACC: begin
                n_state = amrcs_pkg::group_end(r_k) ? amrcs_pkg::S_FAC : amrcs_pkg::S_SN_X;
            end
            amrcs_pkg::S_FAC: begin
                mul_a   = 32'(fsum[31:15]);
                mul_b   = base;
                n_state = amrcs_pkg::S_WGT;
            end
            amrcs_pkg::S_WGT: begin
                n_state = (r_k == amrcs_pkg::PHASE_LAST) ? amrcs_pkg::S_SUM
                                                         : amrcs_pkg::S_SN_X;
            end
            amrcs_pkg::S_SUM: begin
                case (r_cnt)
                    3'd0: begin
                        mul_a = 32'(r_payload);
                        mul_b = 32'(r_w[0]);
                    end
                    3'd1: begin
                        mul_a = 32'(r_echo);
                        mul_b = 32'(r_w[1]);
                    end
                    3'd2: begin
                        mul_a = 32'(r_bg);
                        mul_b = 32'(r_w[2]);
                    end
                    3'd3: begin
                        mul_a = 32'(r_noise);
                        mul_b = 32'(amrcs_pkg::NOISE_WEIGHT);
                    end
                    3'd4: begin
                        mul_a = 32'(r_tone);
                        mul_b = 32'(r_w[3]);
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
                if (r_cnt == amrcs_pkg::SUM_TERMS) begin
                    n_state = amrcs_pkg::S_DIV;
                end
            end
            amrcs_pkg::S_DIV: begin
                div_req.start = 1'b1;
                div_req.num   = r_num;
                div_req.den   = {total, 7'b0};
                n_state       = amrcs_pkg::S_DIVW;
            end
            amrcs_pkg::S_DIVW: begin
                if (div_done) begin
                    n_state = amrcs_pkg::S_OUT;
                end
            end
            amrcs_pkg::S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    ram_we   = 1'b1;
                    n_state  = amrcs_pkg::S_ADV;
                end
            end
            amrcs_pkg::S_ADV: begin
                if (r_k == amrcs_pkg::PHASE_LAST) begin
                    n_state = amrcs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = amrcs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_pos       <= '0;
            r_started   <= 1'b0;
            r_seed      <= '0;
            r_level     <= amrcs_pkg::LEVEL_RESET;
            r_rand      <= '0;
            r_noise     <= '0;
            r_prev      <= '0;
            r_acc       <= '0;
            r_k         <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NP; i++) begin
                r_phase[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    amrcs_pkg::CFG_SEED:  r_seed  <= i_cfg_data;
                    amrcs_pkg::CFG_LEVEL: r_level <= i_cfg_data[9:0];
                    default: ;
                endcase
            end
            if (out_load) begin
                r_out_valid  <= 1'b1;
                r_out_sample <= res_sum[16:9];
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                amrcs_pkg::S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                end
                amrcs_pkg::S_IDLE: begin
                    if (i_in_valid) begin
                        r_payload <= i_payload_sample;
                        r_bg      <= i_background_sample;
                        r_k       <= '0;
                        if (!r_started) begin
                            r_rand <= (r_seed == 32'd0) ? 32'd1 : r_seed;
                        end
                    end
                end
                amrcs_pkg::S_INIT_DRAW: begin
                    r_rand <= d_next;
                end
                amrcs_pkg::S_INIT_STEP: begin
                    if (div_done) begin
                        r_step[r_k] <= div_q[31:0];
                        if (r_k == amrcs_pkg::PHASE_LAST) begin
                            r_started <= 1'b1;
                            r_k       <= '0;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                amrcs_pkg::S_ITEM: begin
                    r_rand  <= d_next;
                    r_noise <= 8'((9'(r_noise) + 9'(d_next[7:0])) >> 1);
                    r_k     <= '0;
                    r_acc   <= '0;
                end
                amrcs_pkg::S_ECHO: begin
                    r_echo <= ram_rdata;
                end
                amrcs_pkg::S_SN_X: begin
                    r_x   <= x_fold;
                    r_neg <= quad[1];
                end
                amrcs_pkg::S_SN_X2: begin
                    r_x2 <= p[32:16];
                end
                amrcs_pkg::S_SN_ACC: begin
                    if (r_k == amrcs_pkg::TONE_INDEX) begin
                        r_tone <= r_neg ? (amrcs_pkg::TONE_BIAS - p[22:0])
                                        : (amrcs_pkg::TONE_BIAS + p[22:0]);
                    end else begin
                        r_acc <= r_neg ? (r_acc - sprod) : (r_acc + sprod);
                    end
                    if (!amrcs_pkg::group_end(r_k)) begin
                        r_k <= r_k + 1'b1;
                    end
                end
                amrcs_pkg::S_WGT: begin
                    r_w[grp] <= w_new;
                    r_acc    <= '0;
                    if (r_k == amrcs_pkg::PHASE_LAST) begin
                        r_k   <= '0;
                        r_cnt <= '0;
                        r_num <= '0;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                amrcs_pkg::S_SUM: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt != 3'd0) begin
                        r_num <= r_num + sum_add;
                    end
                end
                amrcs_pkg::S_DIVW: begin
                    if (div_done) begin
                        r_mix <= mix_clip;
                    end
                end
                amrcs_pkg::S_OUT: begin
                    if (out_load) begin
                        r_pos  <= pos_next;
                        r_prev <= r_mix;
                        r_k    <= '0;
                    end
                end
                amrcs_pkg::S_ADV: begin
                    r_phase[r_k] <= r_phase[r_k] + r_step[r_k];
                    r_k <= (r_k == amrcs_pkg::PHASE_LAST) ? '0 : r_k + 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_in_stall     = (r_state != amrcs_pkg::S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_radio_sample = r_out_sample;
    assign o_cfg_ready    = 1'b1;

endmodule

FILE: rtl/amrcs_mul.sv
// Shared 32 by 32 unsigned multiplier with a registered product.
// Depends on nothing.
module amrcs_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = r_p;

endmodule

FILE: rtl/amrcs_div.sv
// Restoring divider, one quotient bit per cycle, giving quotient and remainder.
// Depends on amrcs_pkg for the operand widths and the request struct.
module amrcs_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  amrcs_pkg::t_div_req        i_req,
    output logic                       o_done,
    output logic [amrcs_pkg::DIV_NW-1:0] o_quot,
    output logic [amrcs_pkg::DIV_DW-1:0] o_rem
);

    localparam int NW = amrcs_pkg::DIV_NW;
    localparam int DW = amrcs_pkg::DIV_DW;
    localparam int CW = $clog2(NW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_num;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    assign trial = {r_rem, r_num[NW-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NW-2:0], ge};
            r_rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;
    assign o_rem  = r_rem;

endmodule

FILE: rtl/amrcs_ram.sv
// Generic single write port, single read port RAM with a registered read.
// Depends on nothing.
module amrcs_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 1000,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/amrcs_checker.sv
// Port-level assertions of the AM radio channel simulator and the bind that attaches them.
// Depends on the top level's port list.
module amrcs_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [7:0]                    o_radio_sample
);

    // A busy block takes no second beat in the cycle after one is accepted.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input beat accepted while the previous one is still at work");

    // A result appears only while the block is still finishing its beat.
    a_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_stall)
        else $error("output beat appeared while the block was idle");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_radio_sample))
        else $error("output sample changed while stalled");

endmodule

bind am_radio_channel_simulator amrcs_checker u_amrcs_checker (.*);
